>>> rtl/core/prioritized_chime_sequencer_top_assert.svh
// Assertion macros shared by the checker of the chime sequencer.
`ifndef PRIORITIZED_CHIME_SEQUENCER_TOP_ASSERT_SVH
`define PRIORITIZED_CHIME_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("chime sequencer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("chime sequencer check failed");

`endif

>>> rtl/core/pcs_pkg.sv
package pcs_pkg;

  localparam int NumTunes = 6;
  localparam int MaxSteps = 13;
  localparam int InWidth  = 40;
  localparam int OutWidth = 24;

  typedef enum logic [1:0] {
    KIND_ON,
    KIND_OFF,
    KIND_REST
  } kind_e;

  typedef enum logic [2:0] {
    TUNE_CONNECT,
    TUNE_DISCONNECT,
    TUNE_SHARE,
    TUNE_START,
    TUNE_OVER,
    TUNE_FINISH
  } tune_e;

  typedef struct packed {
    kind_e       kind;
    logic [9:0]  wait_ms;
    logic [9:0]  tone;
  } step_t;

  typedef struct packed {
    logic [5:0]  pending;
    logic [3:0]  step;
    logic [31:0] stamp;
    logic        buzzer;
    logic [9:0]  compare;
    logic        running;
  } state_t;

  localparam logic [3:0] TuneLen [NumTunes] = '{4'd4, 4'd2, 4'd6, 4'd9, 4'd2, 4'd13};

  localparam step_t Pad = '{KIND_REST, 10'd0, 10'd0};

  localparam step_t TuneRom [NumTunes][MaxSteps] = '{
    '{'{KIND_ON, 10'd0, 10'd150}, '{KIND_OFF, 10'd100, 10'd0},
      '{KIND_ON, 10'd20, 10'd100}, '{KIND_OFF, 10'd350, 10'd0},
      Pad, Pad, Pad, Pad, Pad, Pad, Pad, Pad, Pad},
    '{'{KIND_ON, 10'd0, 10'd150}, '{KIND_OFF, 10'd100, 10'd0},
      Pad, Pad, Pad, Pad, Pad, Pad, Pad, Pad, Pad, Pad, Pad},
    '{'{KIND_ON, 10'd0, 10'd150}, '{KIND_OFF, 10'd100, 10'd0},
      '{KIND_ON, 10'd20, 10'd100}, '{KIND_OFF, 10'd100, 10'd0},
      '{KIND_ON, 10'd20, 10'd90}, '{KIND_OFF, 10'd350, 10'd0},
      Pad, Pad, Pad, Pad, Pad, Pad, Pad},
    '{'{KIND_ON, 10'd0, 10'd435}, '{KIND_OFF, 10'd100, 10'd0},
      '{KIND_ON, 10'd20, 10'd360}, '{KIND_OFF, 10'd100, 10'd0},
      '{KIND_ON, 10'd20, 10'd293}, '{KIND_OFF, 10'd100, 10'd0},
      '{KIND_ON, 10'd20, 10'd219}, '{KIND_OFF, 10'd200, 10'd0},
      '{KIND_REST, 10'd500, 10'd0}, Pad, Pad, Pad, Pad},
    '{'{KIND_ON, 10'd0, 10'd904}, '{KIND_OFF, 10'd1000, 10'd0},
      Pad, Pad, Pad, Pad, Pad, Pad, Pad, Pad, Pad, Pad, Pad},
    '{'{KIND_ON, 10'd0, 10'd200}, '{KIND_OFF, 10'd100, 10'd0},
      '{KIND_ON, 10'd20, 10'd200}, '{KIND_OFF, 10'd100, 10'd0},
      '{KIND_ON, 10'd20, 10'd200}, '{KIND_OFF, 10'd100, 10'd0},
      '{KIND_ON, 10'd20, 10'd100}, '{KIND_OFF, 10'd250, 10'd0},
      '{KIND_ON, 10'd20, 10'd150}, '{KIND_OFF, 10'd75, 10'd0},
      '{KIND_ON, 10'd20, 10'd100}, '{KIND_OFF, 10'd400, 10'd0},
      '{KIND_REST, 10'd500, 10'd0}}
  };

endpackage

>>> rtl/core/prioritized_chime_sequencer_top.sv
// A tick's result is registered in the output buffer before it shows on the master side.
// Throughput: one tick per cycle while the output buffer is not full; the tune table lookup
// and 32-bit elapsed-time compare are combinational from input handshake to result register.
// A two-entry output buffer keeps ticks flowing while one result waits to be taken.
// Reset (rst_ni low, asynchronous) clears all tune state and empties the output buffer.
module prioritized_chime_sequencer_top
  import pcs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // now_ms [31:0], request_mask [37:32], zero fill [39:38]
  input  logic [InWidth-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // buzzer_on [0], tone_compare [10:1], counter_running [11], pending_mask [17:12],
  // tune_step [21:18], zero fill [23:22]
  output logic [OutWidth-1:0] m_axis_tdata
);

  state_t              state_q, state_d;
  logic                accept;
  logic                full;
  logic [OutWidth-1:0] result;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  pcs_step u_step (
    .cur_i          (state_q),
    .now_ms_i       (s_axis_tdata[31:0]),
    .request_mask_i (s_axis_tdata[37:32]),
    .nxt_o          (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  assign result = {2'b00, state_d.step, state_d.pending, state_d.running,
                   state_d.compare, state_d.buzzer};

  pcs_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (result),
    .full_o  (full),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

endmodule

>>> rtl/core/pcs_step.sv
module pcs_step
  import pcs_pkg::*;
(
  input  state_t      cur_i,
  input  logic [31:0] now_ms_i,
  input  logic [5:0]  request_mask_i,
  output state_t      nxt_o
);

  logic [5:0]  pend;
  logic        have;
  tune_e       tune;
  step_t       ent;
  logic [3:0]  len;
  logic [31:0] elapsed;
  logic        due;
  logic [4:0]  step_inc;

  always_comb begin
    pend = cur_i.pending | request_mask_i;
    have = 1'b0;
    tune = TUNE_CONNECT;
    // Scan from the lowest priority (highest index) up so the highest pending tune (lowest index) wins.
    for (int i = NumTunes - 1; i >= 0; i--) begin
      if (pend[i]) begin
        have = 1'b1;
        tune = tune_e'(3'(i));
      end
    end
  end

  assign ent      = TuneRom[tune][cur_i.step];
  assign len      = TuneLen[tune];
  assign elapsed  = now_ms_i - cur_i.stamp;
  assign due      = (cur_i.step == 4'd0) || (elapsed > {22'd0, ent.wait_ms});
  assign step_inc = {1'b0, cur_i.step} + 5'd1;

  always_comb begin
    nxt_o = cur_i;
    nxt_o.pending = pend;
    if (have) begin
      if (cur_i.step >= len) begin
        // The game-over tune drops the disconnect flag here and stays pending.
        if (tune == TUNE_OVER) begin
          nxt_o.pending[TUNE_DISCONNECT] = 1'b0;
        end else begin
          nxt_o.pending[tune] = 1'b0;
        end
        nxt_o.step = 4'd0;
      end else if (due) begin
        unique case (ent.kind)
          KIND_ON: begin
            nxt_o.buzzer  = 1'b1;
            nxt_o.running = 1'b1;
            nxt_o.compare = ent.tone;
          end
          KIND_OFF: begin
            nxt_o.buzzer  = 1'b0;
            nxt_o.running = 1'b0;
            nxt_o.compare = 10'd0;
          end
          default: begin
          end
        endcase
        nxt_o.stamp = now_ms_i;
        if (step_inc >= {1'b0, len}) begin
          nxt_o.pending[tune] = 1'b0;
          nxt_o.step = 4'd0;
        end else begin
          nxt_o.step = step_inc[3:0];
        end
      end
    end
  end

endmodule

>>> rtl/core/pcs_out_buf.sv
module pcs_out_buf
  import pcs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [OutWidth-1:0] data_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [OutWidth-1:0] data_o
);

  logic                out_valid_q, out_valid_d;
  logic                skid_valid_q, skid_valid_d;
  logic [OutWidth-1:0] out_q, out_d;
  logic [OutWidth-1:0] skid_q, skid_d;
  logic                pop;

  assign pop = out_valid_q && ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      // A push only happens while the skid slot is empty.
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = data_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

>>> rtl/core/pcs_checker.sv
`include "prioritized_chime_sequencer_top_assert.svh"

module pcs_checker
  import pcs_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutWidth-1:0] m_axis_tdata
);

  logic       stall;
  logic       buzzer;
  logic       running;
  logic [9:0] compare;
  logic [3:0] step;

  assign stall   = m_axis_tvalid && !m_axis_tready;
  assign buzzer  = m_axis_tdata[0];
  assign compare = m_axis_tdata[10:1];
  assign running = m_axis_tdata[11];
  assign step    = m_axis_tdata[21:18];

  // A stalled result must hold its value.
  `PCS_ASSERT_NEXT(a_hold, stall, m_axis_tvalid && $stable(m_axis_tdata))

  // The buzzer, the timer run bit and a nonzero compare value always move together.
  `PCS_ASSERT_NOW(a_tone, m_axis_tvalid, (running == buzzer) && (buzzer == (compare != 10'd0)))

  // The shared step index never passes the last step of the longest tune.
  `PCS_ASSERT_NOW(a_step, m_axis_tvalid, step < 4'd13)

  // Input back-pressure only appears while a result is waiting.
  `PCS_ASSERT_NOW(a_bp, !s_axis_tready, m_axis_tvalid)

endmodule

bind prioritized_chime_sequencer_top pcs_checker u_pcs_checker (.*);
